/* rtl/kvi_pkg.sv */
package kvi_pkg;

  localparam int KVI_MAX_KEYS  = 64;
  localparam int KVI_FRAC_BITS = 16;

  localparam logic [1:0] FUNC_APPEND = 2'd0;
  localparam logic [1:0] FUNC_QUERY  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic        [1:0]  func;
    logic        [31:0] key_time;
    logic signed [31:0] key_x;
    logic signed [31:0] key_y;
    logic signed [31:0] key_z;
    logic        [31:0] query_time;
  } in_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
  } out_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec_t;

  typedef struct packed {
    logic [31:0] ktime;
    vec_t        vec;
  } key_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_SCAN,
    ST_DIV,
    ST_LERP,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    LS_IDLE,
    LS_MUL,
    LS_ADD
  } lerp_state_t;

  function automatic out_t mk_out(logic [1:0] st, vec_t v);
    out_t o;
    o.status = st;
    o.out_x  = v.x;
    o.out_y  = v.y;
    o.out_z  = v.z;
    return o;
  endfunction

endpackage

/* rtl/kvi_keymem.sv */
module kvi_keymem import kvi_pkg::*; #(
  parameter int DEPTH = KVI_MAX_KEYS,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] waddr,
  input  key_t          wdata,
  input  logic          rd_en,
  input  logic [AW-1:0] raddr,
  output key_t          rdata
);

  key_t mem_r [DEPTH];
  key_t rdata_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/kvi_div.sv */
module kvi_div #(
  parameter int FRAC_BITS = 16,
  localparam int QW = FRAC_BITS + 1,
  localparam int CW = $clog2(QW + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [31:0]   num,
  input  logic [31:0]   den,
  output logic          done,
  output logic [QW-1:0] quot
);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] step_r;
  logic [32:0]   rem_r;
  logic [31:0]   den_r;
  logic [QW-1:0] quot_r;

  logic [32:0] trial;
  logic        ge;
  logic [32:0] rem_nxt;

  // The numerator never exceeds the divisor, so the first step compares it
  // unshifted and yields the integer bit of the fraction.
  always_comb begin
    trial   = (step_r == '0) ? rem_r : {rem_r[31:0], 1'b0};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? (trial - {1'b0, den_r}) : trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        rem_r  <= {1'b0, num};
        den_r  <= den;
        quot_r <= '0;
      end else if (busy_r) begin
        rem_r  <= rem_nxt;
        quot_r <= {quot_r[QW-2:0], ge};
        step_r <= step_r + 1'b1;
        if (step_r == CW'(QW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

/* rtl/kvi_lerp.sv */
module kvi_lerp import kvi_pkg::*; #(
  parameter int FRAC_BITS = KVI_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  vec_t               va,
  input  vec_t               vb,
  input  logic [FRAC_BITS:0] frac,
  output logic               done,
  output vec_t               res
);

  localparam int PW = FRAC_BITS + 35;
  localparam logic signed [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

  lerp_state_t lst_r, lst_nxt;
  logic [1:0]  comp_r, comp_nxt;
  logic        done_r, done_nxt;
  logic signed [PW-1:0] prod_r;
  vec_t        res_r;

  logic signed [31:0]   a_c;
  logic signed [31:0]   b_c;
  logic signed [32:0]   diff;
  logic signed [PW-1:0] prod_c;
  logic signed [PW-1:0] rnd;
  logic signed [PW-1:0] shr;
  logic        [31:0]   v_c;

  // One multiplier serves the three components in turn.
  always_comb begin
    case (comp_r)
      2'd0: begin
        a_c = va.x;
        b_c = vb.x;
      end
      2'd1: begin
        a_c = va.y;
        b_c = vb.y;
      end
      default: begin
        a_c = va.z;
        b_c = vb.z;
      end
    endcase
    diff   = $signed({b_c[31], b_c}) - $signed({a_c[31], a_c});
    prod_c = diff * $signed({1'b0, frac});
    rnd    = prod_r + HALF;
    shr    = rnd >>> FRAC_BITS;
    v_c    = a_c + shr[31:0];
  end

  always_comb begin
    lst_nxt  = lst_r;
    comp_nxt = comp_r;
    done_nxt = 1'b0;
    case (lst_r)
      LS_IDLE: begin
        if (start) begin
          comp_nxt = 2'd0;
          lst_nxt  = LS_MUL;
        end
      end
      LS_MUL: begin
        lst_nxt = LS_ADD;
      end
      LS_ADD: begin
        if (comp_r == 2'd2) begin
          done_nxt = 1'b1;
          lst_nxt  = LS_IDLE;
        end else begin
          comp_nxt = comp_r + 2'd1;
          lst_nxt  = LS_MUL;
        end
      end
      default: begin
        lst_nxt = LS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lst_r  <= LS_IDLE;
      comp_r <= 2'd0;
      done_r <= 1'b0;
    end else begin
      lst_r  <= lst_nxt;
      comp_r <= comp_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (lst_r == LS_MUL) begin
      prod_r <= prod_c;
    end
    if (lst_r == LS_ADD) begin
      case (comp_r)
        2'd0:    res_r.x <= v_c;
        2'd1:    res_r.y <= v_c;
        default: res_r.z <= v_c;
      endcase
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

/* rtl/keyframe_vector_interpolator_core.sv */
// Keyframe table with linear interpolation between keys.
// Input beats (in_valid/in_ready, in_data) carry a function code: append a
// key, query at a time, or clear the table. Every input beat yields exactly one
// result beat (out_valid/out_ready, out_data) with a status and a vector.
// The block works on one beat at a time; in_ready is high only when idle.
// Append, clear and unused codes pass from acceptance through ST_OUT to a result.
// A query reads the key memory one entry per cycle through its single read
// port until it finds the segment that holds the query time or the last key,
// then runs the restoring divider and the shared multiplier and loads the
// result. The next beat can be accepted in the same cycle as the result appears.
// Results sit in an output register; if the receiver stalls, a finished result
// waits there and the next one holds in the core until the register drains.
// Reset empties the table and drops any beat in flight; the key memory itself
// is not cleared, since only entries below the key count are ever read.
module keyframe_vector_interpolator_core import kvi_pkg::*; #(
  parameter int MAX_KEYS  = KVI_MAX_KEYS,
  parameter int FRAC_BITS = KVI_FRAC_BITS
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int AW = $clog2(MAX_KEYS);
  localparam int CW = $clog2(MAX_KEYS + 1);

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [31:0]   qt_r, qt_nxt;
  key_t          prev_r, prev_nxt;
  out_t          res_r, res_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_t          out_data_r, out_data_nxt;

  logic          wr_en;
  key_t          wdata;
  logic          rd_en;
  logic [AW-1:0] raddr;
  key_t          cur;

  logic               div_start;
  logic               div_done;
  logic [FRAC_BITS:0] frac;
  logic               lerp_start;
  logic               lerp_done;
  vec_t               lerp_res;

  localparam vec_t ZERO_VEC = '0;

  assign wdata.ktime = in_data.key_time;
  assign wdata.vec.x = in_data.key_x;
  assign wdata.vec.y = in_data.key_y;
  assign wdata.vec.z = in_data.key_z;

  kvi_keymem #(.DEPTH(MAX_KEYS)) u_mem (
    .clk   (clk),
    .wr_en (wr_en),
    .waddr (count_r[AW-1:0]),
    .wdata (wdata),
    .rd_en (rd_en),
    .raddr (raddr),
    .rdata (cur)
  );

  kvi_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (qt_r - prev_r.ktime),
    .den   (cur.ktime - prev_r.ktime),
    .done  (div_done),
    .quot  (frac)
  );

  kvi_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (lerp_start),
    .va    (prev_r.vec),
    .vb    (cur.vec),
    .frac  (frac),
    .done  (lerp_done),
    .res   (lerp_res)
  );

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    qt_nxt        = qt_r;
    prev_nxt      = prev_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    raddr         = idx_r;
    div_start     = 1'b0;
    lerp_start    = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          res_nxt   = mk_out(STATUS_OK, ZERO_VEC);
          state_nxt = ST_OUT;
          case (in_data.func)
            FUNC_APPEND: begin
              if (count_r == CW'(MAX_KEYS)) begin
                res_nxt = mk_out(STATUS_FULL, ZERO_VEC);
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            FUNC_QUERY: begin
              qt_nxt = in_data.query_time;
              if (count_r == '0) begin
                res_nxt = mk_out(STATUS_EMPTY, ZERO_VEC);
              end else begin
                rd_en     = 1'b1;
                raddr     = '0;
                idx_nxt   = '0;
                state_nxt = ST_FIRST;
              end
            end
            FUNC_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_FIRST: begin
        if (count_r == CW'(1) || qt_r <= cur.ktime) begin
          res_nxt   = mk_out(STATUS_OK, cur.vec);
          state_nxt = ST_OUT;
        end else begin
          prev_nxt  = cur;
          rd_en     = 1'b1;
          raddr     = AW'(1);
          idx_nxt   = AW'(1);
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // prev_r holds key idx_r - 1, cur holds key idx_r.
        if (prev_r.ktime <= qt_r && qt_r <= cur.ktime) begin
          if (cur.ktime == prev_r.ktime) begin
            res_nxt   = mk_out(STATUS_OK, prev_r.vec);
            state_nxt = ST_OUT;
          end else begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end
        end else if (CW'(idx_r) == count_r - CW'(1)) begin
          res_nxt   = mk_out(STATUS_OK, cur.vec);
          state_nxt = ST_OUT;
        end else begin
          prev_nxt = cur;
          rd_en    = 1'b1;
          raddr    = idx_r + 1'b1;
          idx_nxt  = idx_r + 1'b1;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          lerp_start = 1'b1;
          state_nxt  = ST_LERP;
        end
      end
      ST_LERP: begin
        if (lerp_done) begin
          res_nxt   = mk_out(STATUS_OK, lerp_res);
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    qt_r       <= qt_nxt;
    prev_r     <= prev_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* verif/testbench.sv */
module testbench;
  import kvi_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_BEATS = 590;
  localparam int HOLD_CYCLES  = 300;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  keyframe_vector_interpolator_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  // Shadow copy of the keyframe table.
  logic [31:0] key_times [KVI_MAX_KEYS];
  vec_t        key_vecs  [KVI_MAX_KEYS];
  int          key_count = 0;

  out_t pending_results [$];

  int  error_count = 0;
  int  results_checked = 0;
  int  beats_sent = 0;
  int  append_beats = 0;
  int  query_beats = 0;
  int  clear_beats = 0;
  int  unused_beats = 0;
  int  cycle_count = 0;
  int  hold_left = 0;
  bit  steady = 1'b0;

  function automatic out_t vec_result(input vec_t v);
    out_t r;
    r.status = STATUS_OK;
    r.out_x  = v.x;
    r.out_y  = v.y;
    r.out_z  = v.z;
    return r;
  endfunction

  function automatic logic signed [31:0] blend_component(input logic signed [31:0] a,
      input logic signed [31:0] b, input logic [KVI_FRAC_BITS:0] frac);
    logic signed [63:0] ea;
    logic signed [63:0] eb;
    logic signed [63:0] prod;
    logic signed [63:0] rounded;
    ea = a;
    eb = b;
    prod = (eb - ea) * $signed({{(63 - KVI_FRAC_BITS){1'b0}}, frac});
    // The arithmetic shift floors, which gives round-half-up with the bias.
    rounded = (prod + (64'sd1 <<< (KVI_FRAC_BITS - 1))) >>> KVI_FRAC_BITS;
    return a + rounded[31:0];
  endfunction

  function automatic out_t lookup_vector(input logic [31:0] t);
    out_t r;
    logic [31:0] t0;
    logic [31:0] t1;
    logic [31:0] span;
    logic [31:0] offset;
    logic [63:0] quotient;
    logic [KVI_FRAC_BITS:0] frac;
    bit hit;
    r = '0;
    hit = 1'b0;
    if (key_count == 0) begin
      r.status = STATUS_EMPTY;
      return r;
    end
    if (key_count == 1 || t <= key_times[0]) return vec_result(key_vecs[0]);
    for (int k = 0; k + 1 < key_count && !hit; k++) begin
      t0 = key_times[k];
      t1 = key_times[k + 1];
      if (t0 <= t && t <= t1) begin
        hit = 1'b1;
        span = t1 - t0;
        if (span == 32'd0) begin
          r = vec_result(key_vecs[k]);
        end else begin
          offset = t - t0;
          quotient = ({32'd0, offset} << KVI_FRAC_BITS) / {32'd0, span};
          frac = quotient[KVI_FRAC_BITS:0];
          r.status = STATUS_OK;
          r.out_x = blend_component(key_vecs[k].x, key_vecs[k + 1].x, frac);
          r.out_y = blend_component(key_vecs[k].y, key_vecs[k + 1].y, frac);
          r.out_z = blend_component(key_vecs[k].z, key_vecs[k + 1].z, frac);
        end
      end
    end
    if (!hit) r = vec_result(key_vecs[key_count - 1]);
    return r;
  endfunction

  function automatic out_t predict_keyframe_result(input in_t item);
    out_t r;
    r = '0;
    case (item.func)
      FUNC_APPEND: begin
        if (key_count >= KVI_MAX_KEYS) begin
          r.status = STATUS_FULL;
        end else begin
          key_times[key_count] = item.key_time;
          key_vecs[key_count].x = item.key_x;
          key_vecs[key_count].y = item.key_y;
          key_vecs[key_count].z = item.key_z;
          key_count++;
        end
      end
      FUNC_QUERY: r = lookup_vector(item.query_time);
      FUNC_CLEAR: key_count = 0;
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_result_beat(input out_t got);
    out_t want;
    if (pending_results.size() == 0) begin
      error_count++;
      if (error_count <= 10)
        $display("ERROR: result beat with nothing pending: status %0d xyz %h %h %h",
                 got.status, got.out_x, got.out_y, got.out_z);
      return;
    end
    want = pending_results.pop_front();
    results_checked++;
    if (got.status !== want.status || got.out_x !== want.out_x ||
        got.out_y !== want.out_y || got.out_z !== want.out_z) begin
      error_count++;
      if (error_count <= 10)
        $display("ERROR: result %0d: expected status %0d xyz %h %h %h, got status %0d xyz %h %h %h",
                 results_checked, want.status, want.out_x, want.out_y, want.out_z,
                 got.status, got.out_x, got.out_y, got.out_z);
    end
  endtask

  // Receiver side: checks every beat and drives out_ready.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result_beat(out_data);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (steady) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 22);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles, %0d results pending",
               cycle_count, pending_results.size());
      $display("keyframe_vector_interpolator_core verification failed");
      $finish;
    end
  end

  // Offers one beat and returns at the edge where it is accepted.
  task automatic offer_beat(input in_t item);
    while (!steady && $urandom_range(0, 99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    pending_results.insert(pending_results.size(), predict_keyframe_result(item));
    beats_sent++;
    case (item.func)
      FUNC_APPEND: append_beats++;
      FUNC_QUERY:  query_beats++;
      FUNC_CLEAR:  clear_beats++;
      default:     unused_beats++;
    endcase
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic in_t random_beat();
    in_t item;
    item.func       = 2'($urandom_range(0, 3));
    item.key_time   = $urandom;
    item.key_x      = $urandom;
    item.key_y      = $urandom;
    item.key_z      = $urandom;
    item.query_time = $urandom;
    return item;
  endfunction

  function automatic in_t make_append(input logic [31:0] t, input logic [31:0] x,
      input logic [31:0] y, input logic [31:0] z);
    in_t item;
    item = random_beat();
    item.func     = FUNC_APPEND;
    item.key_time = t;
    item.key_x    = x;
    item.key_y    = y;
    item.key_z    = z;
    return item;
  endfunction

  function automatic in_t make_query(input logic [31:0] t);
    in_t item;
    item = random_beat();
    item.func       = FUNC_QUERY;
    item.query_time = t;
    return item;
  endfunction

  function automatic in_t make_op(input logic [1:0] func);
    in_t item;
    item = random_beat();
    item.func = func;
    return item;
  endfunction

  function automatic logic [31:0] pick_component();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3, 4:    return $urandom;
      default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  task automatic test_empty_table();
    offer_beat(make_query(32'h0000_0000));
    offer_beat(make_op(FUNC_UNUSED));
    offer_beat(make_op(FUNC_CLEAR));
    offer_beat(make_query(32'hFFFF_FFFF));
  endtask

  task automatic test_single_key();
    offer_beat(make_append(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
    offer_beat(make_query(32'h0000_0000));
    offer_beat(make_query(32'hFFFF_FFFF));
    offer_beat(make_query(32'h1234_5678));
  endtask

  task automatic test_segment_cases();
    offer_beat(make_op(FUNC_CLEAR));
    offer_beat(make_append(32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000));
    offer_beat(make_append(32'h0003_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000));
    // A repeated key time forms a zero-length segment.
    offer_beat(make_append(32'h0003_0000, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000));
    offer_beat(make_append(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF));
    // Out of order: stored as given.
    offer_beat(make_append(32'h0002_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
    offer_beat(make_query(32'h0000_0000));
    offer_beat(make_query(32'h0001_0000));
    offer_beat(make_query(32'h0002_0000));
    offer_beat(make_query(32'h0002_AAAA));
    offer_beat(make_query(32'h0003_0000));
    offer_beat(make_query(32'h8000_0000));
    offer_beat(make_query(32'hFFFF_FFFF));
  endtask

  task automatic test_full_table();
    logic [31:0] t;
    t = $urandom_range(0, 32'h1000);
    offer_beat(make_op(FUNC_CLEAR));
    for (int k = 0; k < KVI_MAX_KEYS; k++) begin
      offer_beat(make_append(t, pick_component(), pick_component(), pick_component()));
      if (k != KVI_MAX_KEYS - 1) t = t + $urandom_range(1, 32'h8000);
    end
    offer_beat(make_append($urandom, $urandom, $urandom, $urandom));
    offer_beat(make_append(t + 32'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
    for (int k = 0; k < 4; k++) offer_beat(make_query($urandom_range(0, t)));
    offer_beat(make_query(t));
    offer_beat(make_query(32'hFFFF_FFFF));
    offer_beat(make_op(FUNC_CLEAR));
    offer_beat(make_query($urandom));
  endtask

  // The receiver stalls while the sender keeps offering, so the block backs up.
  task automatic test_receiver_holdoff();
    hold_left = HOLD_CYCLES;
    offer_beat(make_op(FUNC_CLEAR));
    for (int k = 0; k < 6; k++)
      offer_beat(make_append(32'(k) << 16, pick_component(), pick_component(),
                             pick_component()));
    for (int k = 0; k < 5; k++) offer_beat(make_query($urandom_range(0, 32'h0006_0000)));
    wait_for_drain();
  endtask

  task automatic run_animation(input int n_keys, input int n_queries);
    logic [31:0] times [$];
    logic [31:0] t;
    logic [31:0] lo;
    logic [31:0] hi;
    int k;
    in_t item;
    offer_beat(make_op(FUNC_CLEAR));
    t = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0010_0000);
    for (int n = 0; n < n_keys; n++) begin
      item = make_append(t, pick_component(), pick_component(), pick_component());
      if ($urandom_range(0, 15) == 0) item.key_time = $urandom;
      offer_beat(item);
      times.insert(times.size(), item.key_time);
      case ($urandom_range(0, 7))
        0:       t = t;
        1:       t = t + $urandom;
        default: t = t + $urandom_range(1, 32'h0004_0000);
      endcase
    end
    for (int n = 0; n < n_queries; n++) begin
      if ($urandom_range(0, 19) == 0) begin
        item = random_beat();
        if ($urandom_range(0, 1) == 0) item.func = FUNC_UNUSED;
        offer_beat(item);
      end
      k = $urandom_range(0, times.size() - 1);
      case ($urandom_range(0, 7))
        0:       t = times[k];
        1:       t = (times[0] == 32'd0) ? 32'd0 : $urandom_range(0, times[0] - 32'd1);
        2:       t = times[times.size() - 1] + $urandom_range(0, 32'h0001_0000);
        3:       t = $urandom;
        default: begin
          if (k + 1 < times.size()) begin
            lo = times[k];
            hi = times[k + 1];
            t = (hi > lo) ? lo + $urandom_range(0, hi - lo) : times[k];
          end else begin
            t = times[k];
          end
        end
      endcase
      offer_beat(make_query(t));
    end
  endtask

  task automatic test_random_animations();
    int start;
    int n_keys;
    start = beats_sent;
    while (beats_sent - start < RANDOM_BEATS) begin
      // One window runs with neither side idling.
      steady = (beats_sent - start >= 250 && beats_sent - start < 370);
      case ($urandom_range(0, 15))
        0:       n_keys = $urandom_range(20, KVI_MAX_KEYS + 2);
        1:       n_keys = 1;
        default: n_keys = $urandom_range(2, 8);
      endcase
      run_animation(n_keys, $urandom_range(3, 10));
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_single_key();
    test_segment_cases();
    test_full_table();
    test_receiver_holdoff();
    test_random_animations();
    wait_for_drain();
    repeat (20) @(posedge clk);
    $display("Run covered %0d beats: %0d appends, %0d queries, %0d clears, %0d unused codes.",
             beats_sent, append_beats, query_beats, clear_beats, unused_beats);
    $display("Checked %0d result beats, %0d errors, including a full table and a long stall.",
             results_checked, error_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("keyframe_vector_interpolator_core verification clean");
    end else begin
      $display("keyframe_vector_interpolator_core verification failed");
    end
    $finish;
  end

endmodule
